FILE: hdl/dptc_pkg.sv
package dptc_pkg;

  // Field widths
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SPEED_W    = 7;
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned TICKS_W    = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 1'd1;

  // Reset values and limits
  localparam logic [SPEED_W-1:0] SPEED_RESET     = 7'd50;
  localparam logic [SPEED_W-1:0] DUTY_MAX        = 7'd100;
  localparam logic [ANGLE_W-1:0] STEP_RESET      = 8'd10;
  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT     = 8'd180;
  localparam logic [ANGLE_W-1:0] PULSE_MAX_ANGLE = 8'd180;

  // Message lengths
  localparam logic [LEN_W-1:0] LEN_SHORT = 10'd5;
  localparam logic [LEN_W-1:0] LEN_LONG  = 10'd6;

  // Short-form command codes
  localparam logic [BYTE_W-1:0] SC_LEFT    = 8'd1;
  localparam logic [BYTE_W-1:0] SC_RIGHT   = 8'd2;
  localparam logic [BYTE_W-1:0] SC_FWD     = 8'd3;
  localparam logic [BYTE_W-1:0] SC_BACK    = 8'd4;
  localparam logic [BYTE_W-1:0] SC_TILT_DN = 8'd5;
  localparam logic [BYTE_W-1:0] SC_TILT_UP = 8'd6;
  localparam logic [BYTE_W-1:0] SC_PAN_DN  = 8'd7;
  localparam logic [BYTE_W-1:0] SC_PAN_UP  = 8'd8;

  // Long-form command codes
  localparam logic [BYTE_W-1:0] LC_STOP  = 8'd0;
  localparam logic [BYTE_W-1:0] LC_FWD   = 8'd1;
  localparam logic [BYTE_W-1:0] LC_BACK  = 8'd2;
  localparam logic [BYTE_W-1:0] LC_LEFT  = 8'd3;
  localparam logic [BYTE_W-1:0] LC_RIGHT = 8'd4;

  // Servo select
  localparam logic SEL_TILT = 1'b0;
  localparam logic SEL_PAN  = 1'b1;

  // Pulse math: ticks = floor((1024*a + 46305) / 450), the division done
  // as a multiply by a scaled reciprocal (exact over the angle range)
  localparam int unsigned NUM_W       = 18;
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned TICK_SHIFT  = 28;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;
  localparam int unsigned QUOT_W      = PROD_W - TICK_SHIFT;
  localparam logic [NUM_W-1:0]   TICK_OFFSET = 18'd46305;
  localparam logic [RECIP_W-1:0] TICK_RECIP  = 20'd596524;

  typedef enum logic [2:0] {
    DIR_STOP  = 3'd0,
    DIR_FWD   = 3'd1,
    DIR_BACK  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  typedef struct packed {
    logic [LEN_W-1:0]  msg_len;
    logic [BYTE_W-1:0] hdr_byte1;
    logic [BYTE_W-1:0] hdr_byte2;
    logic [BYTE_W-1:0] hdr_byte3;
  } item_t;

  typedef struct packed {
    logic step;
    logic up;
    logic sel;
  } servo_cmd_t;

endpackage

FILE: hdl/dptc_in_stage.sv
module dptc_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dptc_pkg::item_t in_item,
  output logic            hold_valid,
  output dptc_pkg::item_t hold_item,
  input  logic            take
);
  import dptc_pkg::*;

  // Accept when empty or when the held transaction leaves this cycle
  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> hold_valid)
    else $error("transaction taken from an empty input register");

  a_hold_keeps_item: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !take |=> hold_valid && $stable(hold_item))
    else $error("held transaction lost or changed");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> hold_valid)
    else $error("accepted transaction not held");

endmodule

FILE: hdl/dptc_servo.sv
module dptc_servo (
  input  logic                         clk,
  input  logic                         rst,
  input  dptc_pkg::servo_cmd_t         cmd,
  input  logic [dptc_pkg::ANGLE_W-1:0] angle_step,
  output logic [dptc_pkg::TICKS_W-1:0] ticks
);
  import dptc_pkg::*;

  logic [ANGLE_W-1:0] tilt_angle;
  logic [ANGLE_W-1:0] pan_angle;
  logic [ANGLE_W-1:0] cur_angle;
  logic [ANGLE_W:0]   up_sum;
  logic [ANGLE_W-1:0] up_angle;
  logic [ANGLE_W-1:0] dn_angle;
  logic [ANGLE_W-1:0] angle_next;
  logic [ANGLE_W-1:0] pulse_angle;
  logic [NUM_W-1:0]   numer;
  logic [PROD_W-1:0]  prod;

  // Step the selected angle, saturating at zero and the limit
  always_comb begin
    cur_angle = (cmd.sel == SEL_PAN) ? pan_angle : tilt_angle;
    up_sum    = {1'b0, cur_angle} + {1'b0, angle_step};
    up_angle  = (up_sum > {1'b0, ANGLE_LIMIT}) ? ANGLE_LIMIT : up_sum[ANGLE_W-1:0];
    dn_angle  = (angle_step >= cur_angle) ? '0 : cur_angle - angle_step;
    angle_next = cmd.up ? up_angle : dn_angle;
  end

  // Convert the new angle to pulse ticks
  always_comb begin
    pulse_angle = (angle_next > PULSE_MAX_ANGLE) ? PULSE_MAX_ANGLE : angle_next;
    numer = {pulse_angle, {(NUM_W-ANGLE_W){1'b0}}} + TICK_OFFSET;
    prod  = PROD_W'(numer) * PROD_W'(TICK_RECIP);
    ticks = TICKS_W'(prod[PROD_W-1:TICK_SHIFT]);
  end

  // Commit the step
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_angle <= '0;
      pan_angle  <= '0;
    end else if (cmd.step) begin
      if (cmd.sel == SEL_PAN) begin
        pan_angle <= angle_next;
      end else begin
        tilt_angle <= angle_next;
      end
    end
  end

  a_angle_limit: assert property (@(posedge clk) disable iff (rst)
    tilt_angle <= ANGLE_LIMIT && pan_angle <= ANGLE_LIMIT)
    else $error("servo angle beyond limit");

  a_idle_keeps_angles: assert property (@(posedge clk) disable iff (rst)
    !cmd.step |=> $stable(tilt_angle) && $stable(pan_angle))
    else $error("servo angle changed without a step");

  a_other_angle_kept: assert property (@(posedge clk) disable iff (rst)
    cmd.step && cmd.sel == SEL_PAN |=> $stable(tilt_angle))
    else $error("pan step disturbed tilt angle");

endmodule

FILE: hdl/drive_and_pan_tilt_command_decoder.sv
// Drive and pan/tilt command decoder.
// Input channel (in_valid/in_ready): one transaction is one received command
// message, given as msg_len and the header bytes hdr_byte1..hdr_byte3.
// Output channel (out_valid/out_ready): exactly one result per message, with
// the wheel direction lines and duty (drive_valid) or a servo pulse width in
// 1/4096 frame ticks (servo_valid), or neither for an unknown six-byte code.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 drive speed, 1 angle step) at the clock edge; write only while idle.
// An accepted message passes from the input register to the output register,
// which hands it on while out_ready is high. Throughput: one message per cycle
// while the receiver does not stall; the input register and the output register
// each hold one transaction, and the tilt/pan angle update plus the tick
// multiply sit between them.
// Reset (rst, synchronous): both channels empty, speed 50, step 10, angles 0.
// When the receiver stalls the result holds on the output, one more message
// waits in the input register, then in_ready drops.
module drive_and_pan_tilt_command_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dptc_pkg::LEN_W-1:0]      msg_len,
  input  logic [dptc_pkg::BYTE_W-1:0]     hdr_byte1,
  input  logic [dptc_pkg::BYTE_W-1:0]     hdr_byte2,
  input  logic [dptc_pkg::BYTE_W-1:0]     hdr_byte3,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            drive_valid,
  output logic                            left_fwd,
  output logic                            left_rev,
  output logic                            right_fwd,
  output logic                            right_rev,
  output logic [dptc_pkg::SPEED_W-1:0]    wheel_duty,
  output logic                            servo_valid,
  output logic                            servo_sel,
  output logic [dptc_pkg::TICKS_W-1:0]    servo_ticks,
  input  logic                            cfg_wr_en,
  input  logic [dptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dptc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dptc_pkg::*;

  logic [SPEED_W-1:0] drive_speed;
  logic [ANGLE_W-1:0] angle_step;
  item_t              in_item;
  item_t              hold_item;
  logic               hold_valid;
  logic               take;
  logic               drive_en;
  logic               servo_en;
  dir_t               dir;
  servo_cmd_t         scmd;
  logic [TICKS_W-1:0] ticks;
  logic [SPEED_W-1:0] duty;

  assign in_item = '{msg_len: msg_len, hdr_byte1: hdr_byte1,
                     hdr_byte2: hdr_byte2, hdr_byte3: hdr_byte3};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_speed <= SPEED_RESET;
      angle_step  <= STEP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DRIVE_SPEED: drive_speed <= cfg_data[SPEED_W-1:0];
        CFG_ANGLE_STEP:  angle_step  <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  dptc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take)
  );

  // Advance when the output register is free or being drained
  assign take = hold_valid && (!out_valid || out_ready);

  // Decode the held message
  always_comb begin
    drive_en = 1'b0;
    servo_en = 1'b0;
    dir      = DIR_STOP;
    scmd     = '0;
    if (hold_item.msg_len == LEN_SHORT) begin
      if (hold_item.hdr_byte1 != '0) begin
        drive_en = 1'b1;
      end else begin
        case (hold_item.hdr_byte2)
          SC_FWD:     begin drive_en = 1'b1; dir = DIR_FWD; end
          SC_BACK:    begin drive_en = 1'b1; dir = DIR_BACK; end
          SC_LEFT:    begin drive_en = 1'b1; dir = DIR_LEFT; end
          SC_RIGHT:   begin drive_en = 1'b1; dir = DIR_RIGHT; end
          SC_TILT_UP: begin servo_en = 1'b1; scmd.up = 1'b1; scmd.sel = SEL_TILT; end
          SC_TILT_DN: begin servo_en = 1'b1; scmd.up = 1'b0; scmd.sel = SEL_TILT; end
          SC_PAN_UP:  begin servo_en = 1'b1; scmd.up = 1'b1; scmd.sel = SEL_PAN; end
          SC_PAN_DN:  begin servo_en = 1'b1; scmd.up = 1'b0; scmd.sel = SEL_PAN; end
          default:    drive_en = 1'b1;
        endcase
      end
    end else if (hold_item.msg_len == LEN_LONG) begin
      if (hold_item.hdr_byte2 != '0) begin
        drive_en = 1'b1;
      end else begin
        case (hold_item.hdr_byte3)
          LC_FWD:   begin drive_en = 1'b1; dir = DIR_FWD; end
          LC_BACK:  begin drive_en = 1'b1; dir = DIR_BACK; end
          LC_LEFT:  begin drive_en = 1'b1; dir = DIR_LEFT; end
          LC_RIGHT: begin drive_en = 1'b1; dir = DIR_RIGHT; end
          LC_STOP:  drive_en = 1'b1;
          default:  ;
        endcase
      end
    end else begin
      drive_en = 1'b1;
    end
    scmd.step = servo_en && take;
  end

  dptc_servo u_servo (
    .clk        (clk),
    .rst        (rst),
    .cmd        (scmd),
    .angle_step (angle_step),
    .ticks      (ticks)
  );

  // Clamp speed to full duty; zero on stop
  assign duty = (dir == DIR_STOP) ? '0 :
                (drive_speed > DUTY_MAX) ? DUTY_MAX : drive_speed;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      drive_valid <= drive_en;
      left_fwd    <= drive_en && (dir == DIR_FWD || dir == DIR_RIGHT);
      left_rev    <= drive_en && (dir == DIR_BACK || dir == DIR_LEFT);
      right_fwd   <= drive_en && (dir == DIR_FWD || dir == DIR_LEFT);
      right_rev   <= drive_en && (dir == DIR_BACK || dir == DIR_RIGHT);
      wheel_duty  <= drive_en ? duty : '0;
      servo_valid <= servo_en;
      servo_sel   <= servo_en && scmd.sel;
      servo_ticks <= servo_en ? ticks : '0;
    end
  end

  a_single_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_valid && servo_valid))
    else $error("result is both drive and servo");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(servo_ticks) && $stable(wheel_duty))
    else $error("stalled result changed");

  a_idle_drive_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_valid |-> !left_fwd && !left_rev && !right_fwd && !right_rev
      && wheel_duty == '0)
    else $error("drive lines set without drive update");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wheel_duty <= DUTY_MAX)
    else $error("wheel duty above full scale");

endmodule
